// ===== hw/rtl/text_console_char_writer_defines.svh =====
// Assertion macros shared by the console writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

   localparam int CURSOR_COL_WIDTH = 7;
   localparam int CURSOR_ROW_WIDTH = 5;
   localparam int CHAR_WIDTH       = 8;
   localparam int ATTR_WIDTH       = 8;
   localparam int CELL_WIDTH       = CHAR_WIDTH + ATTR_WIDTH;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE     = 8'd10;
   localparam logic [CHAR_WIDTH-1:0] CHAR_RETURN      = 8'd13;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE       = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PRINT_FIRST = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PRINT_LAST  = 8'd126;
   localparam logic [ATTR_WIDTH-1:0] RESET_ATTR       = 8'd7;

   typedef enum logic [1:0] {
      FUNC_PUT        = 2'd0,
      FUNC_CLEAR      = 2'd1,
      FUNC_SET_CURSOR = 2'd2,
      FUNC_READ_CELL  = 2'd3
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic put_step;
      logic set_cursor;
      logic capture_read;
      logic clear_start;
      logic clear_run;
      logic scroll_start;
      logic scroll_run;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     put_scroll;
      logic     clear_end;
      logic     scroll_end;
   } dp_status_type;

endpackage

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console character writer.
// The block holds a screen of SCREEN_COLUMNS x SCREEN_ROWS cells, each a
// character byte and an attribute byte, plus a cursor and a current attribute.
// A request transfer happens at a clock edge where start is high and busy is
// low; req_func selects put character, clear screen, set cursor or read cell.
// Exactly one response transfer follows each request: rsp_strobe is high for
// one cycle with the cursor, the cell read back and the scroll flag.
// The receiver cannot stall, so the response must be taken in that cycle.
// Put without scroll, set cursor, carriage return and an ignored code are
// answered from the execute state; read cell passes through a read state
// first (registered cell memory read); clear runs a sweep over all CELLS cells,
// and a put that scrolls runs a scroll sweep, where CELLS is columns times rows.
// Scroll and clear sweep the cell memory one cell per cycle over its single
// write port; that sweep sets the cost of those operations.
// Requests do not overlap: a new one is taken only once busy is low again.
// After reset the block runs a clearing pass over all CELLS cells (2000 at the
// default size) that fills the screen with spaces in attribute 7; busy stays
// high meanwhile. The clear attribute register may be written at any time
// through csr_write_enable, and is used by the next clear operation.
`include "text_console_char_writer_defines.svh"

module text_console_char_writer
   import tccw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_func,
   input  logic [CHAR_WIDTH-1:0]       req_character,
   input  logic [ATTR_WIDTH-1:0]       req_attribute,
   input  logic [CURSOR_COL_WIDTH-1:0] req_column_in,
   input  logic [CURSOR_ROW_WIDTH-1:0] req_row_in,
   output logic                        rsp_strobe,
   output logic [CURSOR_COL_WIDTH-1:0] rsp_cursor_column,
   output logic [CURSOR_ROW_WIDTH-1:0] rsp_cursor_row,
   output logic [CHAR_WIDTH-1:0]       rsp_cell_char,
   output logic [ATTR_WIDTH-1:0]       rsp_cell_attr,
   output logic                        rsp_scrolled,
   input  logic                        csr_write_enable,
   input  logic [ATTR_WIDTH-1:0]       csr_write_data
);

   // The controller sequences each operation; the datapath owns the cell
   // memory, cursor, attributes and sweep counter.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tccw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (dp_status),
      .cmd        (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tccw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_func          (req_func),
      .req_character     (req_character),
      .req_attribute     (req_attribute),
      .req_column_in     (req_column_in),
      .req_row_in        (req_row_in),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_scrolled      (rsp_scrolled)
   );

   // An accepted request makes the block busy before any response is shown.
   `TCCW_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe, "accepted request did not make the block busy")
   // A response is only shown once the block has returned to idle.
   `TCCW_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy, "response strobe while busy")
   // A scroll always leaves the cursor at column 0 of the last row.
   `TCCW_ASSERT_NOW(a_scroll_cursor, clock, reset, rsp_strobe && rsp_scrolled, (rsp_cursor_column == '0) && (rsp_cursor_row == CURSOR_ROW_WIDTH'(SCREEN_ROWS - 1)), "scroll left the cursor off the last row start")

endmodule

// ===== hw/rtl/tccw_ram.sv =====
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tccw_ctrl.sv =====
module tccw_ctrl
   import tccw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_CLEAR,
      ST_SCROLL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_strobe_ff;
   logic      rsp_strobe_in;

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.clear_run = 1'b1;
            if (status.clear_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.func)
               FUNC_PUT: begin
                  cmd.put_step = 1'b1;
                  if (status.put_scroll) begin
                     cmd.scroll_start = 1'b1;
                     state_in         = ST_SCROLL;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  state_in        = ST_CLEAR;
               end
               FUNC_SET_CURSOR: begin
                  cmd.set_cursor = 1'b1;
                  rsp_strobe_in  = 1'b1;
                  state_in       = ST_IDLE;
               end
               FUNC_READ_CELL: begin
                  state_in = ST_READ;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            cmd.capture_read = 1'b1;
            rsp_strobe_in    = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (status.clear_end) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            cmd.scroll_run = 1'b1;
            if (status.scroll_end) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

endmodule

// ===== hw/rtl/tccw_datapath.sv =====
module tccw_datapath
   import tccw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status,
   input  logic [1:0]                  req_func,
   input  logic [CHAR_WIDTH-1:0]       req_character,
   input  logic [ATTR_WIDTH-1:0]       req_attribute,
   input  logic [CURSOR_COL_WIDTH-1:0] req_column_in,
   input  logic [CURSOR_ROW_WIDTH-1:0] req_row_in,
   input  logic                        csr_write_enable,
   input  logic [ATTR_WIDTH-1:0]       csr_write_data,
   output logic [CURSOR_COL_WIDTH-1:0] rsp_cursor_column,
   output logic [CURSOR_ROW_WIDTH-1:0] rsp_cursor_row,
   output logic [CHAR_WIDTH-1:0]       rsp_cell_char,
   output logic [ATTR_WIDTH-1:0]       rsp_cell_attr,
   output logic                        rsp_scrolled
);

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int KEEP_COUNT = CELL_COUNT - SCREEN_COLUMNS;
   localparam int COL_W      = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   // Captured request, coordinates already clamped to the screen.
   func_type              func_ff;
   logic [CHAR_WIDTH-1:0] char_ff;
   logic [ATTR_WIDTH-1:0] attr_ff;
   logic [COL_W-1:0]      req_col_ff;
   logic [ROW_W-1:0]      req_row_ff;

   logic [COL_W-1:0]      cur_col_ff;
   logic [COL_W-1:0]      cur_col_in;
   logic [ROW_W-1:0]      cur_row_ff;
   logic [ROW_W-1:0]      cur_row_in;
   logic [ATTR_WIDTH-1:0] cur_attr_ff;
   logic [ATTR_WIDTH-1:0] clear_attr_ff;
   logic [ATTR_WIDTH-1:0] fill_attr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  scrolled_ff;
   logic [CHAR_WIDTH-1:0] cell_char_ff;
   logic [ATTR_WIDTH-1:0] cell_attr_ff;

   logic                  is_print;
   logic                  is_newline;
   logic                  is_return;
   logic                  at_last_col;
   logic                  at_last_row;
   logic [ADDR_W-1:0]     cursor_addr;
   logic [ADDR_W-1:0]     req_addr;
   logic [ADDR_W-1:0]     scroll_rd_addr;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [CELL_WIDTH-1:0] ram_wr_data;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [CELL_WIDTH-1:0] ram_rd_data;

   assign is_print    = char_ff inside {[CHAR_PRINT_FIRST:CHAR_PRINT_LAST]};
   assign is_newline  = (char_ff == CHAR_NEWLINE);
   assign is_return   = (char_ff == CHAR_RETURN);
   assign at_last_col = (cur_col_ff == LAST_COL);
   assign at_last_row = (cur_row_ff == LAST_ROW);

   assign cursor_addr = ADDR_W'(ADDR_W'(cur_row_ff) * ADDR_W'(SCREEN_COLUMNS)
                                + ADDR_W'(cur_col_ff));
   assign req_addr    = ADDR_W'(ADDR_W'(req_row_ff) * ADDR_W'(SCREEN_COLUMNS)
                                + ADDR_W'(req_col_ff));

   // During a scroll, step k reads the cell one row below cell k.
   assign scroll_rd_addr = (32'(cnt_ff) + SCREEN_COLUMNS < CELL_COUNT)
                           ? ADDR_W'(32'(cnt_ff) + SCREEN_COLUMNS) : '0;

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (cmd.clear_start) begin
         cur_col_in = '0;
         cur_row_in = '0;
      end else if (cmd.set_cursor) begin
         cur_col_in = req_col_ff;
         cur_row_in = req_row_ff;
      end else if (cmd.put_step) begin
         if (is_newline || (is_print && at_last_col)) begin
            cur_col_in = '0;
            if (!at_last_row) begin
               cur_row_in = cur_row_ff + 1'b1;
            end
         end else if (is_return) begin
            cur_col_in = '0;
         end else if (is_print) begin
            cur_col_in = cur_col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_addr;
      ram_wr_data = {char_ff, attr_ff};
      if (cmd.clear_run) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = ADDR_W'(cnt_ff);
         ram_wr_data = {CHAR_SPACE, fill_attr_ff};
      end else if (cmd.scroll_run) begin
         // Step k writes cell k-1 with the data read at step k-1, or a blank on the last row.
         ram_wr_en   = (cnt_ff != '0);
         ram_wr_addr = ADDR_W'(cnt_ff - 1'b1);
         ram_wr_data = (32'(cnt_ff) <= KEEP_COUNT) ? ram_rd_data
                                                   : {CHAR_SPACE, cur_attr_ff};
      end else if (cmd.put_step && is_print) begin
         ram_wr_en = 1'b1;
      end
   end

   assign ram_rd_addr = cmd.scroll_run ? scroll_rd_addr : req_addr;

   tccw_ram #(
      .WIDTH (CELL_WIDTH),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff    <= func_type'(req_func);
         char_ff    <= req_character;
         attr_ff    <= req_attribute;
         req_col_ff <= (32'(req_column_in) >= SCREEN_COLUMNS)
                       ? LAST_COL : COL_W'(req_column_in);
         req_row_ff <= (32'(req_row_in) >= SCREEN_ROWS)
                       ? LAST_ROW : ROW_W'(req_row_in);
      end
      if (cmd.load_req) begin
         scrolled_ff  <= 1'b0;
         cell_char_ff <= '0;
         cell_attr_ff <= '0;
      end else begin
         if (cmd.scroll_start) begin
            scrolled_ff <= 1'b1;
         end
         if (cmd.capture_read) begin
            cell_char_ff <= ram_rd_data[CELL_WIDTH-1:ATTR_WIDTH];
            cell_attr_ff <= ram_rd_data[ATTR_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         cur_attr_ff   <= RESET_ATTR;
         clear_attr_ff <= RESET_ATTR;
         fill_attr_ff  <= RESET_ATTR;
         cnt_ff        <= '0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         if (cmd.put_step && is_print) begin
            cur_attr_ff <= attr_ff;
         end
         if (csr_write_enable) begin
            clear_attr_ff <= csr_write_data;
         end
         if (cmd.clear_start) begin
            fill_attr_ff <= clear_attr_ff;
         end
         if (cmd.clear_start || cmd.scroll_start) begin
            cnt_ff <= '0;
         end else if (cmd.clear_run || cmd.scroll_run) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign status.func       = func_ff;
   assign status.put_scroll = (is_newline || (is_print && at_last_col)) && at_last_row;
   assign status.clear_end  = (cnt_ff == CNT_W'(CELL_COUNT - 1));
   assign status.scroll_end = (cnt_ff == CNT_W'(CELL_COUNT));

   assign rsp_cursor_column = CURSOR_COL_WIDTH'(cur_col_ff);
   assign rsp_cursor_row    = CURSOR_ROW_WIDTH'(cur_row_ff);
   assign rsp_cell_char     = cell_char_ff;
   assign rsp_cell_attr     = cell_attr_ff;
   assign rsp_scrolled      = scrolled_ff;

endmodule

// ===== tb/sv/text_console_char_writer_tb.sv =====
`timescale 1ns / 100ps

module text_console_char_writer_tb;
   import tccw_pkg::*;

   localparam int COLUMNS         = 80;
   localparam int ROWS            = 25;
   localparam int CELLS           = COLUMNS * ROWS;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 243;
   // Among the short operations read cell is the slowest: it passes through
   // an extra read state before its response.
   localparam int SETTLE_CYCLES   = 8;

   logic                        clock             = 1'b0;
   logic                        reset             = 1'b1;
   logic                        start             = 1'b0;
   logic                        busy;
   logic [1:0]                  req_func          = FUNC_PUT;
   logic [CHAR_WIDTH-1:0]       req_character     = '0;
   logic [ATTR_WIDTH-1:0]       req_attribute     = '0;
   logic [CURSOR_COL_WIDTH-1:0] req_column_in     = '0;
   logic [CURSOR_ROW_WIDTH-1:0] req_row_in        = '0;
   logic                        rsp_strobe;
   logic [CURSOR_COL_WIDTH-1:0] rsp_cursor_column;
   logic [CURSOR_ROW_WIDTH-1:0] rsp_cursor_row;
   logic [CHAR_WIDTH-1:0]       rsp_cell_char;
   logic [ATTR_WIDTH-1:0]       rsp_cell_attr;
   logic                        rsp_scrolled;
   logic                        csr_write_enable  = 1'b0;
   logic [ATTR_WIDTH-1:0]       csr_write_data    = '0;

   text_console_char_writer #(
      .SCREEN_COLUMNS (COLUMNS),
      .SCREEN_ROWS    (ROWS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_character     (req_character),
      .req_attribute     (req_attribute),
      .req_column_in     (req_column_in),
      .req_row_in        (req_row_in),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_scrolled      (rsp_scrolled),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   typedef struct {
      func_type                    func;
      logic [CHAR_WIDTH-1:0]       character;
      logic [ATTR_WIDTH-1:0]       attribute;
      logic [CURSOR_COL_WIDTH-1:0] column_in;
      logic [CURSOR_ROW_WIDTH-1:0] row_in;
   } console_req_type;

   typedef struct {
      logic [CURSOR_COL_WIDTH-1:0] cursor_column;
      logic [CURSOR_ROW_WIDTH-1:0] cursor_row;
      logic [CHAR_WIDTH-1:0]       cell_char;
      logic [ATTR_WIDTH-1:0]       cell_attr;
      logic                        scrolled;
   } console_rsp_type;

   // One row of the directed table. Where typed is set, rsp holds the
   // response written out by hand; otherwise the screen predictor decides.
   typedef struct {
      console_req_type req;
      bit              typed;
      console_rsp_type rsp;
   } console_step_type;

   // Shadow copy of the console: cell store, cursor, the attribute of the
   // last printed character and the clear attribute register.
   logic [CHAR_WIDTH-1:0] screen_char [CELLS];
   logic [ATTR_WIDTH-1:0] screen_attr [CELLS];
   int unsigned           cursor_col;
   int unsigned           cursor_row;
   logic [ATTR_WIDTH-1:0] pen_attr;
   logic [ATTR_WIDTH-1:0] clear_attr;

   console_rsp_type  pending_rsp [$];
   console_step_type directed_plan [$];

   int error_count   = 0;
   int request_count = 0;
   int rsp_count     = 0;
   int scroll_count  = 0;
   int clear_count   = 0;
   int idle_pct      = 0;

   // The clock toggles every nanosecond, for a 2 ns period.
   initial begin
      forever #1 clock = ~clock;
   end

   // Generous upper bound: even if every request scrolled, sweeping all cells,
   // after the longest sender gap, the run would need about 7 ms.
   initial begin
      #30_000_000;
      $display("Timed out with %0d responses still pending.", pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] %s", $time, msg);
   endtask

   function automatic void fill_screen(input logic [ATTR_WIDTH-1:0] attr);
      int i;
      for (i = 0; i < CELLS; i++) begin
         screen_char[i] = CHAR_SPACE;
         screen_attr[i] = attr;
      end
   endfunction

   function automatic int unsigned clamp(input int unsigned value, input int unsigned lim);
      return (value >= lim) ? lim - 1 : value;
   endfunction

   // Moves the cursor to the start of the next row. On the last row the
   // whole screen moves up one row and the freed bottom row is blanked in the
   // attribute of the last printed character; the return value flags that.
   function automatic bit advance_line();
      int i;
      cursor_col = 0;
      if (cursor_row + 1 < ROWS) begin
         cursor_row++;
         return 1'b0;
      end
      for (i = 0; i < CELLS - COLUMNS; i++) begin
         screen_char[i] = screen_char[i + COLUMNS];
         screen_attr[i] = screen_attr[i + COLUMNS];
      end
      for (i = CELLS - COLUMNS; i < CELLS; i++) begin
         screen_char[i] = CHAR_SPACE;
         screen_attr[i] = pen_attr;
      end
      return 1'b1;
   endfunction

   // Applies one request to the shadow console and returns the response the
   // block must give for it.
   function automatic void console_apply(input console_req_type req,
                                         output console_rsp_type rsp);
      int unsigned col_sel;
      int unsigned row_sel;
      int unsigned pos;
      bit          scrolled;
      col_sel       = clamp(32'(req.column_in), COLUMNS);
      row_sel       = clamp(32'(req.row_in), ROWS);
      scrolled      = 1'b0;
      rsp.cell_char = '0;
      rsp.cell_attr = '0;
      case (req.func)
         FUNC_PUT: begin
            if (req.character == CHAR_NEWLINE) begin
               scrolled = advance_line();
            end else if (req.character == CHAR_RETURN) begin
               cursor_col = 0;
            end else if (req.character >= CHAR_PRINT_FIRST &&
                         req.character <= CHAR_PRINT_LAST) begin
               pos              = cursor_row * COLUMNS + cursor_col;
               screen_char[pos] = req.character;
               screen_attr[pos] = req.attribute;
               pen_attr         = req.attribute;
               if (cursor_col + 1 < COLUMNS) begin
                  cursor_col++;
               end else begin
                  scrolled = advance_line();
               end
            end
            // Any other code leaves the console untouched.
         end
         FUNC_CLEAR: begin
            fill_screen(clear_attr);
            cursor_col = 0;
            cursor_row = 0;
            clear_count++;
         end
         FUNC_SET_CURSOR: begin
            cursor_col = col_sel;
            cursor_row = row_sel;
         end
         FUNC_READ_CELL: begin
            pos           = row_sel * COLUMNS + col_sel;
            rsp.cell_char = screen_char[pos];
            rsp.cell_attr = screen_attr[pos];
         end
         default: begin
         end
      endcase
      rsp.cursor_column = CURSOR_COL_WIDTH'(cursor_col);
      rsp.cursor_row    = CURSOR_ROW_WIDTH'(cursor_row);
      rsp.scrolled      = scrolled;
      if (scrolled) begin
         scroll_count++;
      end
   endfunction

   task automatic add_step(input func_type f, input int ch, input int at, input int col,
                           input int row, input bit typed, input int ecol, input int erow,
                           input int echar, input int eattr, input int escr);
      console_step_type step;
      step.req.func          = f;
      step.req.character     = CHAR_WIDTH'(ch);
      step.req.attribute     = ATTR_WIDTH'(at);
      step.req.column_in     = CURSOR_COL_WIDTH'(col);
      step.req.row_in        = CURSOR_ROW_WIDTH'(row);
      step.typed             = typed;
      step.rsp.cursor_column = CURSOR_COL_WIDTH'(ecol);
      step.rsp.cursor_row    = CURSOR_ROW_WIDTH'(erow);
      step.rsp.cell_char     = CHAR_WIDTH'(echar);
      step.rsp.cell_attr     = ATTR_WIDTH'(eattr);
      step.rsp.scrolled      = 1'(escr);
      directed_plan.push_back(step);
   endtask

   // Random requests lean toward printing, with the cursor often parked near
   // the bottom right so that row wraps and scrolls happen regularly. Clears
   // are rare because each one sweeps the whole cell store.
   function automatic console_req_type random_request();
      console_req_type req;
      int unsigned     pick;
      req.character = CHAR_WIDTH'($urandom_range(255));
      req.attribute = ATTR_WIDTH'($urandom_range(255));
      req.column_in = CURSOR_COL_WIDTH'($urandom_range(COLUMNS - 1));
      req.row_in    = CURSOR_ROW_WIDTH'($urandom_range(ROWS - 1));
      pick          = $urandom_range(99);
      if (pick < 70) begin
         req.func = FUNC_PUT;
         pick     = $urandom_range(99);
         if (pick < 72) begin
            req.character = CHAR_WIDTH'($urandom_range(CHAR_PRINT_LAST, CHAR_PRINT_FIRST));
         end else if (pick < 80) begin
            req.character = CHAR_NEWLINE;
         end else if (pick < 85) begin
            req.character = CHAR_RETURN;
         end
         // The remaining picks keep the raw random byte, mostly an ignored code.
      end else if (pick < 88) begin
         req.func = FUNC_READ_CELL;
         if ($urandom_range(9) == 0) begin
            req.column_in = CURSOR_COL_WIDTH'($urandom_range(127));
            req.row_in    = CURSOR_ROW_WIDTH'($urandom_range(31));
         end
      end else if (pick < 99) begin
         req.func = FUNC_SET_CURSOR;
         if ($urandom_range(1) == 0) begin
            req.column_in = CURSOR_COL_WIDTH'($urandom_range(COLUMNS - 1, COLUMNS - 12));
            req.row_in    = CURSOR_ROW_WIDTH'($urandom_range(31, ROWS - 2));
         end else begin
            req.column_in = CURSOR_COL_WIDTH'($urandom_range(127));
            req.row_in    = CURSOR_ROW_WIDTH'($urandom_range(31));
         end
      end else begin
         req.func = FUNC_CLEAR;
      end
      return req;
   endfunction

   // Holds start high with the request fields until a transfer happens at an
   // edge where busy is low. The expected response is queued at that edge;
   // the block answers only after its execute state, so the response monitor
   // always finds it waiting. A random idle burst may follow the transfer.
   task automatic send_request(input console_step_type step);
      console_rsp_type predicted;
      start         <= 1'b1;
      req_func      <= step.req.func;
      req_character <= step.req.character;
      req_attribute <= step.req.attribute;
      req_column_in <= step.req.column_in;
      req_row_in    <= step.req.row_in;
      do @(posedge clock); while (busy);
      console_apply(step.req, predicted);
      pending_rsp.push_back(step.typed ? step.rsp : predicted);
      request_count++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
   endtask

   // The clear attribute is written only once every response is in, so that
   // no clear in flight can see the new value.
   task automatic write_clear_attr(input logic [ATTR_WIDTH-1:0] value);
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      clear_attr = value;
   endtask

   // Response monitor. The receiver cannot stall, so every strobe is a
   // transfer and is matched against the oldest pending expectation.
   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("Response transfer arrived with nothing pending.");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_cursor_column !== want.cursor_column) begin
               report_mismatch($sformatf("cursor_column: got %0d, expected %0d",
                                         rsp_cursor_column, want.cursor_column));
            end
            if (rsp_cursor_row !== want.cursor_row) begin
               report_mismatch($sformatf("cursor_row: got %0d, expected %0d",
                                         rsp_cursor_row, want.cursor_row));
            end
            if (rsp_cell_char !== want.cell_char) begin
               report_mismatch($sformatf("cell_char: got %0d, expected %0d",
                                         rsp_cell_char, want.cell_char));
            end
            if (rsp_cell_attr !== want.cell_attr) begin
               report_mismatch($sformatf("cell_attr: got %0d, expected %0d",
                                         rsp_cell_attr, want.cell_attr));
            end
            if (rsp_scrolled !== want.scrolled) begin
               report_mismatch($sformatf("scrolled: got %0d, expected %0d",
                                         rsp_scrolled, want.scrolled));
            end
         end
      end
   end

   initial begin
      console_step_type      step;
      int                    phase;
      int                    n;
      logic [ATTR_WIDTH-1:0] setting;

      clear_attr = RESET_ATTR;
      pen_attr   = RESET_ATTR;
      cursor_col = 0;
      cursor_row = 0;
      fill_screen(RESET_ATTR);

      // Directed table: reset contents, code boundaries, wraps and scrolls,
      // coordinate saturation and a clear at the reset attribute.
      //       func             char  attr  col  row  typ ecol erow echr eatr scr
      add_step(FUNC_READ_CELL,  0,    0,    0,   0,   1,  0,   0,   32,  7,   0);
      add_step(FUNC_READ_CELL,  0,    0,    127, 31,  1,  0,   0,   32,  7,   0);
      add_step(FUNC_PUT,        65,   8'h1E, 0,  0,   1,  1,   0,   0,   0,   0);
      add_step(FUNC_READ_CELL,  0,    0,    0,   0,   1,  1,   0,   65,  8'h1E, 0);
      add_step(FUNC_PUT,        0,    8'h33, 0,  0,   1,  1,   0,   0,   0,   0);
      add_step(FUNC_PUT,        255,  8'h33, 0,  0,   1,  1,   0,   0,   0,   0);
      add_step(FUNC_PUT,        127,  8'h33, 0,  0,   1,  1,   0,   0,   0,   0);
      add_step(FUNC_PUT,        31,   8'h33, 0,  0,   1,  1,   0,   0,   0,   0);
      add_step(FUNC_PUT,        32,   8'hFF, 0,  0,   1,  2,   0,   0,   0,   0);
      add_step(FUNC_PUT,        126,  8'h00, 0,  0,   1,  3,   0,   0,   0,   0);
      add_step(FUNC_PUT,        13,   8'h55, 0,  0,   1,  0,   0,   0,   0,   0);
      add_step(FUNC_PUT,        10,   8'h55, 0,  0,   1,  0,   1,   0,   0,   0);
      add_step(FUNC_SET_CURSOR, 0,    0,    79,  0,   1,  79,  0,   0,   0,   0);
      add_step(FUNC_PUT,        90,   8'h42, 0,  0,   1,  0,   1,   0,   0,   0);
      add_step(FUNC_READ_CELL,  0,    0,    79,  0,   1,  0,   1,   90,  8'h42, 0);
      add_step(FUNC_SET_CURSOR, 0,    0,    0,   24,  1,  0,   24,  0,   0,   0);
      add_step(FUNC_PUT,        10,   8'h99, 0,  0,   1,  0,   24,  0,   0,   1);
      add_step(FUNC_READ_CELL,  0,    0,    79,  24,  1,  0,   24,  32,  8'h42, 0);
      add_step(FUNC_READ_CELL,  0,    0,    0,   0,   0,  0,   0,   0,   0,   0);
      add_step(FUNC_SET_CURSOR, 0,    0,    127, 31,  1,  79,  24,  0,   0,   0);
      add_step(FUNC_PUT,        113,  8'h5A, 0,  0,   1,  0,   24,  0,   0,   1);
      add_step(FUNC_READ_CELL,  0,    0,    79,  23,  0,  0,   0,   0,   0,   0);
      add_step(FUNC_CLEAR,      0,    0,    0,   0,   1,  0,   0,   0,   0,   0);
      add_step(FUNC_READ_CELL,  0,    0,    40,  12,  1,  0,   0,   32,  7,   0);
      add_step(FUNC_READ_CELL,  0,    0,    100, 2,   0,  0,   0,   0,   0,   0);

      // Synchronous reset comes first. The block then runs its own
      // clearing pass with busy high, which the first transfer waits out.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      foreach (directed_plan[i]) begin
         send_request(directed_plan[i]);
      end
      start <= 1'b0;

      // Random phases, each under its own clear attribute: both extremes
      // first, then random values. Every phase opens with a clear so that
      // the new setting lands on the screen. The last phase runs with the
      // sender never idling.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       setting = 8'hFF;
            1:       setting = 8'h00;
            default: setting = ATTR_WIDTH'($urandom_range(255));
         endcase
         write_clear_attr(setting);
         step.typed   = 1'b0;
         step.rsp     = '{default: '0};
         step.req     = random_request();
         step.req.func = FUNC_CLEAR;
         idle_pct     = 0;
         send_request(step);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Idle density changes in stretches of 50 transfers, some of
            // them with no idling at all.
            if (n % 50 == 0) begin
               case ($urandom_range(3))
                  0:       idle_pct = 0;
                  1:       idle_pct = 5;
                  2:       idle_pct = 25;
                  default: idle_pct = 60;
               endcase
            end
            if (phase == RANDOM_PHASES - 1) begin
               idle_pct = 0;
            end
            step.req = random_request();
            send_request(step);
         end
         start <= 1'b0;
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived.", pending_rsp.size()));
      end

      $display("Sent %0d requests and checked %0d responses, with %0d scrolls and %0d clears.",
               request_count, rsp_count, scroll_count, clear_count);
      $display("Clear attribute went through %0d settings, both extremes included.",
               RANDOM_PHASES + 1);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
